FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL. Each use names its label, the property
// and the message. The clock is clk and the reset is arst_n in every user.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every clock edge once reset is released.
`define LACP_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define LACP_ASSERT_ALW(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LACP_ASSERT_RST(lbl, prop, msg)
`define LACP_ASSERT_ALW(lbl, prop, msg)

`endif

`endif

FILE: sv/lacp_pkg.sv
// ---------------------------------------------------------------------------
// lacp_pkg
// Types and constants of the line address command parser: beat payloads,
// register indexes, ASCII codes and the parse phase encoding.
// ---------------------------------------------------------------------------
package lacp_pkg;

	// Field widths fixed by the interface.
	localparam int FIELD_LINE_W = 24;
	localparam int CHAR_W       = 8;
	localparam int POS_W        = 12;
	localparam int CFG_IDX_W    = 1;

	// Parameter defaults.
	localparam int LINE_BITS_DEF    = 24;
	localparam int MAX_LINE_LEN_DEF = 4096;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LINE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_LINE    = 1'd1;

	// ASCII codes the parser reacts to.
	localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
	localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
	localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
	localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;

	// Parse phase, one-hot.
	typedef enum logic [3:0] {
		PH_FIRST  = 4'b0001,
		PH_SECOND = 4'b0010,
		PH_SKIP   = 4'b0100,
		PH_DONE   = 4'b1000
	} phase_t;

	// Input beat.
	typedef struct packed {
		logic [CHAR_W-1:0] char_in;
		logic              line_begin;
	} item_t;

	// Result beat.
	typedef struct packed {
		logic [FIELD_LINE_W-1:0] range_start;
		logic [FIELD_LINE_W-1:0] range_end;
		logic [CHAR_W-1:0]       command_byte;
		logic [POS_W-1:0]        argument_offset;
	} result_t;

endpackage

FILE: sv/line_address_command_parser_unit.sv
// ---------------------------------------------------------------------------
// line_address_command_parser_unit
// Streaming parser for editor command lines: address range, command byte and
// argument offset.
// ---------------------------------------------------------------------------
// The unit takes one command-line byte per cycle, and a new beat may follow
// in the very next cycle without a gap. Each byte is captured in an input
// register and then updates the parse state; the byte that completes a result
// (the first non-whitespace byte after the command) goes through the input
// register and then the output register. The state update per byte is a single
// step, which includes the multiply by ten of the decimal accumulator. Bytes
// stall only while a finished result waits on the output. The current and last
// line registers are to be written through the cfg port only while the unit is
// idle; the unit does not enforce this. Line arithmetic wraps at LINE_BITS bits.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module line_address_command_parser_unit
	import lacp_pkg::*;
#(
	parameter int LINE_BITS    = LINE_BITS_DEF,
	parameter int MAX_LINE_LEN = MAX_LINE_LEN_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// Input byte channel.
	input  logic                    item_valid,
	output logic                    item_ready,
	input  item_t                   item,
	// Result channel.
	output logic                    result_valid,
	input  logic                    result_ready,
	output result_t                 result,
	// Register write port.
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [FIELD_LINE_W-1:0] cfg_wdata
);

	localparam int LW      = LINE_BITS;
	localparam int POS_CAP = (MAX_LINE_LEN - 1 < 4095) ? (MAX_LINE_LEN - 1) : 4095;

	// Configuration registers.
	logic [LW-1:0] cur_line_q;
	logic [LW-1:0] last_line_q;

	// Input stage.
	logic  valid_s1;
	item_t item_s1;

	// Parse state.
	phase_t           phase_q;
	logic [LW-1:0]    acc_q;
	logic [LW-1:0]    base_q;
	logic             seen_value_q;
	logic             seen_sign_q;
	logic             sign_neg_q;
	logic [LW-1:0]    start_q;
	logic [LW-1:0]    end_q;
	logic [CHAR_W-1:0] cmd_q;
	logic [POS_W-1:0] pos_q;

	// Output register.
	logic    result_valid_q;
	result_t result_q;

	// Handshake control.
	logic advance;
	logic produce;

	// State after an optional line restart.
	phase_t            ph_e;
	logic [LW-1:0]     acc_e;
	logic [LW-1:0]     base_e;
	logic              sv_e;
	logic              ss_e;
	logic              sn_e;
	logic [LW-1:0]     start_e;
	logic [LW-1:0]     end_e;
	logic [CHAR_W-1:0] cmd_e;
	logic [POS_W-1:0]  pos_e;

	// Next-state values.
	phase_t            ph_d;
	logic [LW-1:0]     acc_d;
	logic [LW-1:0]     base_d;
	logic              sv_d;
	logic              ss_d;
	logic              sn_d;
	logic [LW-1:0]     start_d;
	logic [LW-1:0]     end_d;
	logic [CHAR_W-1:0] cmd_d;
	logic [POS_W-1:0]  pos_d;

	// Byte classification and address value.
	logic [CHAR_W-1:0] b;
	logic              is_dot, is_dollar, is_plus, is_minus, is_digit;
	logic              is_addr, is_sep, is_ws;
	logic              addr_present;
	logic [LW-1:0]     addr_value;
	logic [LW-1:0]     first_value;
	logic [63:0]       cfg_ext;
	logic [63:0]       start_ext;
	logic [63:0]       end_ext;

	// The input register frees up whenever its byte moves on.
	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	// Register writes, truncated to the line width.
	assign cfg_ext = 64'(cfg_wdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_line_q  <= '0;
			last_line_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CURRENT_LINE: cur_line_q  <= cfg_ext[LW-1:0];
				REG_LAST_LINE:    last_line_q <= cfg_ext[LW-1:0];
				default:          ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// A line-begin beat starts from the cleared parse state.
	always_comb begin
		b = item_s1.char_in;
		if (item_s1.line_begin) begin
			ph_e    = PH_FIRST;
			acc_e   = '0;
			base_e  = '0;
			sv_e    = 1'b0;
			ss_e    = 1'b0;
			sn_e    = 1'b0;
			start_e = '0;
			end_e   = '0;
			cmd_e   = CH_SPACE;
			pos_e   = '0;
		end else begin
			ph_e    = phase_q;
			acc_e   = acc_q;
			base_e  = base_q;
			sv_e    = seen_value_q;
			ss_e    = seen_sign_q;
			sn_e    = sign_neg_q;
			start_e = start_q;
			end_e   = end_q;
			cmd_e   = cmd_q;
			pos_e   = pos_q;
		end
	end

	// Byte classes.
	always_comb begin
		is_dot    = (b == CH_DOT);
		is_dollar = (b == CH_DOLLAR);
		is_plus   = (b == CH_PLUS);
		is_minus  = (b == CH_MINUS);
		is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
		is_addr   = is_dot || is_dollar || is_plus || is_minus || is_digit;
		is_sep    = (b == CH_COMMA) || (b == CH_SEMI);
		is_ws     = (b == CH_LF) || (b == CH_TAB) || (b == CH_SPACE);
	end

	// Value of the address that ends on this byte.
	always_comb begin
		addr_present = sv_e || ss_e;
		if (ss_e && !sv_e) begin
			addr_value = sn_e ? (cur_line_q - LW'(1)) : (cur_line_q + LW'(1));
		end else if (ss_e && sn_e) begin
			addr_value = base_e - acc_e;
		end else begin
			addr_value = base_e + acc_e;
		end
		first_value = addr_present ? addr_value : cur_line_q;
	end

	// Per-byte parse step.
	always_comb begin
		ph_d    = ph_e;
		acc_d   = acc_e;
		base_d  = base_e;
		sv_d    = sv_e;
		ss_d    = ss_e;
		sn_d    = sn_e;
		start_d = start_e;
		end_d   = end_e;
		cmd_d   = cmd_e;
		pos_d   = (pos_e < POS_W'(POS_CAP)) ? (pos_e + POS_W'(1)) : POS_W'(POS_CAP);
		produce = 1'b0;

		// Address bytes accumulate in either address phase.
		if (is_addr && (ph_e == PH_FIRST || ph_e == PH_SECOND)) begin
			if (is_dot) begin
				sv_d   = 1'b1;
				base_d = cur_line_q;
			end else if (is_dollar) begin
				sv_d   = 1'b1;
				base_d = last_line_q;
			end else if (is_plus) begin
				ss_d   = 1'b1;
				base_d = cur_line_q;
			end else if (is_minus) begin
				ss_d   = 1'b1;
				sn_d   = 1'b1;
				base_d = cur_line_q;
			end else begin
				sv_d  = 1'b1;
				acc_d = (acc_e << 3) + (acc_e << 1) + LW'(b[3:0]);
			end
		end else begin
			case (ph_e)
				PH_FIRST: begin
					acc_d  = '0;
					base_d = '0;
					sv_d   = 1'b0;
					ss_d   = 1'b0;
					sn_d   = 1'b0;
					if (is_sep) begin
						start_d = ((b == CH_COMMA) && !addr_present) ? LW'(1) : first_value;
						end_d   = last_line_q;
						ph_d    = PH_SECOND;
					end else begin
						start_d = first_value;
						end_d   = first_value;
						cmd_d   = b;
						ph_d    = PH_SKIP;
					end
				end
				PH_SECOND: begin
					acc_d  = '0;
					base_d = '0;
					sv_d   = 1'b0;
					ss_d   = 1'b0;
					sn_d   = 1'b0;
					if (addr_present) begin
						end_d = addr_value;
					end
					cmd_d = b;
					ph_d  = PH_SKIP;
				end
				PH_SKIP: begin
					if (!is_ws) begin
						produce = 1'b1;
						ph_d    = PH_DONE;
					end
				end
				default: ;
			endcase
		end
	end

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_FIRST;
			acc_q        <= '0;
			base_q       <= '0;
			seen_value_q <= 1'b0;
			seen_sign_q  <= 1'b0;
			sign_neg_q   <= 1'b0;
			start_q      <= '0;
			end_q        <= '0;
			cmd_q        <= CH_SPACE;
			pos_q        <= '0;
		end else if (advance) begin
			phase_q      <= ph_d;
			acc_q        <= acc_d;
			base_q       <= base_d;
			seen_value_q <= sv_d;
			seen_sign_q  <= ss_d;
			sign_neg_q   <= sn_d;
			start_q      <= start_d;
			end_q        <= end_d;
			cmd_q        <= cmd_d;
			pos_q        <= pos_d;
		end
	end

	// Result fields keep the low 24 bits of the line values.
	assign start_ext = 64'(start_e);
	assign end_ext   = 64'(end_e);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && produce) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			result_q.range_start     <= start_ext[FIELD_LINE_W-1:0];
			result_q.range_end       <= end_ext[FIELD_LINE_W-1:0];
			result_q.command_byte    <= cmd_e;
			result_q.argument_offset <= pos_e;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// A byte that cannot move on stays in the input register unchanged.
	`LACP_ASSERT_RST(a_s1_hold, (valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)), "input stage lost a stalled byte")
	// A produced result shows on the output in the next cycle.
	`LACP_ASSERT_RST(a_result_out, (advance && produce) |=> result_valid, "produced result not presented")
	// After a result the parser waits for the next line.
	`LACP_ASSERT_RST(a_done_after, (advance && produce) |=> (phase_q == PH_DONE), "parser not done after a result")
	// The byte position never passes its saturation point.
	`LACP_ASSERT_RST(a_pos_cap, (pos_q <= POS_W'(POS_CAP)), "byte position beyond its cap")

endmodule
